/* hdl/lte_pkg.sv */
// Shared types and constants for the ledger transfer engine.
// No dependencies; imported by every module of the block but lte_ram.
package lte_pkg;

    localparam int ACCOUNT_COUNT = 65536;
    localparam int ADDR_W        = $clog2(ACCOUNT_COUNT);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int BAL_W         = 64;
    localparam int DATA_W        = 60;
    localparam int CODE_W        = 4;
    localparam int TOTAL_W       = 32;

    localparam logic [BAL_W-1:0]   START_BALANCE = 64'd1000000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

    localparam logic [CODE_W-1:0] OP_TRANSFER  = 4'd0;
    localparam logic [CODE_W-1:0] OP_RANGE_SET = 4'd1;

    typedef struct packed {
        logic [CODE_W-1:0]       operation;
        logic [DATA_W-1:0]       sender_data;
        logic [CODE_W-1:0]       receiver_code;
        logic [DATA_W-1:0]       receiver_data;
        logic signed [BAL_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [TOTAL_W-1:0] success_total;
        logic [TOTAL_W-1:0] failure_total;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_res;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_WRITE_DST,
        ST_FILL,
        ST_RESP
    } t_state;

endpackage

/* hdl/ledger_transfer_engine_core.sv */
// Ledger transfer engine: table of ACCOUNT_COUNT signed 64-bit balances in one RAM.
// Steps from input accept to result valid: a transfer decodes, reads and checks the sender,
// writes it and writes the receiver; a funds refusal stops after the check, a code, index
// or zero-length refusal after decode; a range set decodes, then does one write per entry.
// A new item is taken only after the result has gone to the output register.
// Reset (synchronous, active low) clears the totals, then writes 1000000 to all entries.
module ledger_transfer_engine_core import lte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    // Clearing pass after reset: o_in_ready stays low while all ACCOUNT_COUNT entries are written.

    // RAM request from the sequencer and registered read data back
    t_mem_req         mem_req;
    logic [BAL_W-1:0] mem_rdata;

    // finished item handed to the output stage
    t_res             res;
    logic             res_ready;

    // Balance table. Sender is read in the decode cycle, checked the next cycle
    // while the receiver read goes out; the receiver write follows in the cycle after that.
    lte_ram #(
        .WIDTH (BAL_W),
        .DEPTH (ACCOUNT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer: clearing pass, decode, transfer read-modify-write, range fill
    lte_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output register with the saturating totals; it may hold a result while
    // the sequencer already takes and works on the next item.
    lte_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* hdl/lte_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
module lte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lte_seq.sv */
// Transaction sequencer: decode, balance read-modify-write, range fill, clearing pass.
// Depends on lte_pkg; drives the balance RAM and hands results to lte_out.
module lte_seq import lte_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_item,
    output t_mem_req         o_mem,
    input  logic [BAL_W-1:0] i_rdata,
    output t_res             o_res,
    input  logic             i_res_ready
);

    t_state            r_state, n_state;
    t_in               r_item, n_item;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [BAL_W-1:0]  r_src_new, n_src_new;
    logic              r_ok, n_ok;

    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic              src_in;
    logic              dst_in;
    logic [CNT_W-1:0]  room;
    logic [BAL_W-1:0]  dst_old;
    logic [BAL_W-1:0]  amt_u;

    assign src_addr = r_item.sender_data[ADDR_W-1:0];
    assign dst_addr = r_item.receiver_data[ADDR_W-1:0];
    assign src_in   = r_item.sender_data < DATA_W'(ACCOUNT_COUNT);
    assign dst_in   = r_item.receiver_data < DATA_W'(ACCOUNT_COUNT);
    assign room     = CNT_W'(ACCOUNT_COUNT) - {1'b0, src_addr};
    assign amt_u    = $unsigned(r_item.amount);
    // same-account transfer: sender write lands in the cycle the receiver is read
    assign dst_old  = (dst_addr == src_addr) ? r_src_new : i_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_rem   <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rem   <= n_rem;
            r_ok    <= n_ok;
        end
        r_item    <= n_item;
        r_src_new <= n_src_new;
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_addr     = r_addr;
        n_rem      = r_rem;
        n_src_new  = r_src_new;
        n_ok       = r_ok;
        o_in_ready = 1'b0;
        o_mem      = '0;
        o_res      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_addr;
                o_mem.wdata = START_BALANCE;
                if (r_addr == ADDR_W'(ACCOUNT_COUNT - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_ok    = 1'b0;
                n_state = ST_RESP;
                if (r_item.operation == OP_TRANSFER && r_item.receiver_code == OP_TRANSFER
                        && src_in && dst_in) begin
                    o_mem.raddr = src_addr;
                    n_state     = ST_CHECK;
                end else if (r_item.operation == OP_RANGE_SET
                        && r_item.receiver_code == OP_RANGE_SET
                        && r_item.receiver_data != '0 && src_in) begin
                    n_addr = src_addr;
                    if (r_item.receiver_data > DATA_W'(room)) begin
                        n_rem = room;
                    end else begin
                        n_rem = r_item.receiver_data[CNT_W-1:0];
                    end
                    n_state = ST_FILL;
                end
            end
            ST_CHECK: begin
                if ($signed(i_rdata) >= r_item.amount) begin
                    n_src_new   = i_rdata - amt_u;
                    o_mem.we    = 1'b1;
                    o_mem.waddr = src_addr;
                    o_mem.wdata = i_rdata - amt_u;
                    o_mem.raddr = dst_addr;
                    n_state     = ST_WRITE_DST;
                end else begin
                    n_ok    = 1'b0;
                    n_state = ST_RESP;
                end
            end
            ST_WRITE_DST: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = dst_addr;
                o_mem.wdata = dst_old + amt_u;
                n_ok        = 1'b1;
                n_state     = ST_RESP;
            end
            ST_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_addr;
                o_mem.wdata = amt_u;
                n_addr      = r_addr + 1'b1;
                n_rem       = r_rem - 1'b1;
                if (r_rem == CNT_W'(1)) begin
                    n_ok    = 1'b1;
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                o_res.valid = 1'b1;
                o_res.ok    = r_ok;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/lte_out.sv */
// Output stage: saturating success/failure totals and the result register.
// Depends on lte_pkg.
module lte_out import lte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_res i_res,
    output logic o_res_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    logic               r_valid, n_valid;
    t_out               r_item, n_item;
    logic [TOTAL_W-1:0] r_succ, n_succ;
    logic [TOTAL_W-1:0] r_fail, n_fail;
    logic               load;

    assign o_res_ready = !r_valid || i_out_ready;
    assign load        = i_res.valid && o_res_ready;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        n_succ  = r_succ;
        n_fail  = r_fail;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            if (i_res.ok && r_succ != TOTAL_MAX) begin
                n_succ = r_succ + 1'b1;
            end
            if (!i_res.ok && r_fail != TOTAL_MAX) begin
                n_fail = r_fail + 1'b1;
            end
            n_valid              = 1'b1;
            n_item.accepted      = i_res.ok;
            n_item.success_total = n_succ;
            n_item.failure_total = n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_succ  <= '0;
            r_fail  <= '0;
        end else begin
            r_valid <= n_valid;
            r_succ  <= n_succ;
            r_fail  <= n_fail;
        end
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

/* hdl/lte_chk.sv */
// Port-level checker for the ledger transfer engine, bound to the top level.
// Depends on lte_pkg.
module lte_chk import lte_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_item,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_item
);

    // after reset the clearing pass runs: no item taken, no result shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("item or result during reset");

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_succ_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.accepted |-> o_out_item.success_total != '0)
        else $error("applied item with zero success total");

    a_fail_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.accepted |-> o_out_item.failure_total != '0)
        else $error("rejected item with zero failure total");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind ledger_transfer_engine_core lte_chk u_chk (.*);

/* verif/ledger_transfer_engine_core_test.sv */
`timescale 1ns / 1ps
// Testbench for ledger_transfer_engine_core: transfers, range fills and rejects checked
// against a behavioral ledger model kept here. Depends on lte_pkg and the core RTL.
module ledger_transfer_engine_core_test;
    import lte_pkg::*;

    localparam int STALL_LIMIT  = 300000;  // longer than a full clear plus a full fill
    localparam int RANDOM_ITEMS = 1550;
    localparam int STEADY_LO    = 600;     // no random idling on either side inside this window
    localparam int STEADY_HI    = 900;
    localparam int TAIL_CYCLES  = 50;
    localparam int PRINT_CAP    = 40;

    localparam logic [CODE_W-1:0] OP_SPARE    = 4'd2;
    localparam logic [CODE_W-1:0] OP_TOP_CODE = 4'd15;

    localparam logic [BAL_W-1:0]  AMT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [BAL_W-1:0]  AMT_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] DATA_ONES = '1;

    typedef struct {
        t_in txn;
        bit  drain;   // hold off until every result so far has come back
    } t_pending;

    logic i_clk;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_item  = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_item;

    ledger_transfer_engine_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // ledger model state
    logic [BAL_W-1:0]   ledger [ACCOUNT_COUNT];
    logic [TOTAL_W-1:0] applied_total;
    logic [TOTAL_W-1:0] rejected_total;

    t_pending txn_q[$];
    t_out     totals_q[$];

    int n_sent;
    int n_recv;
    int n_mismatch;
    int n_xfer_ok;
    int n_fill_ok;
    int n_reject;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one transaction to the model and return the result it should produce.
    function automatic t_out post_ledger_txn(input t_in txn);
        t_out             res;
        logic             ok;
        logic [BAL_W-1:0] from_bal;
        logic [DATA_W:0]  stop;
        int unsigned      a;
        ok = 1'b0;
        if (txn.operation == OP_TRANSFER && txn.receiver_code == OP_TRANSFER) begin
            if (txn.sender_data < DATA_W'(ACCOUNT_COUNT) &&
                txn.receiver_data < DATA_W'(ACCOUNT_COUNT)) begin
                from_bal = ledger[txn.sender_data[ADDR_W-1:0]];
                if ($signed(from_bal) >= $signed(txn.amount)) begin
                    // sender written first, so a self transfer nets to zero
                    ledger[txn.sender_data[ADDR_W-1:0]] = from_bal - txn.amount;
                    ledger[txn.receiver_data[ADDR_W-1:0]] =
                        ledger[txn.receiver_data[ADDR_W-1:0]] + txn.amount;
                    ok = 1'b1;
                    n_xfer_ok++;
                end
            end
        end else if (txn.operation == OP_RANGE_SET && txn.receiver_code == OP_RANGE_SET) begin
            if (txn.receiver_data != '0 && txn.sender_data < DATA_W'(ACCOUNT_COUNT)) begin
                stop = {1'b0, txn.sender_data} + {1'b0, txn.receiver_data};
                if (stop > (DATA_W+1)'(ACCOUNT_COUNT))
                    stop = (DATA_W+1)'(ACCOUNT_COUNT);
                a = int'(txn.sender_data[ADDR_W-1:0]);
                while (a < stop) begin
                    ledger[a] = txn.amount;
                    a++;
                end
                ok = 1'b1;
                n_fill_ok++;
            end
        end
        if (ok) begin
            if (applied_total != TOTAL_MAX)
                applied_total++;
        end else begin
            n_reject++;
            if (rejected_total != TOTAL_MAX)
                rejected_total++;
        end
        res.accepted      = ok;
        res.success_total = applied_total;
        res.failure_total = rejected_total;
        return res;
    endfunction

    function automatic logic [BAL_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [DATA_W-1:0] rand60();
        return DATA_W'({$urandom, $urandom});
    endfunction

    // Accounts cluster at both ends of the table so transfers keep colliding.
    function automatic logic [DATA_W-1:0] pick_account();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return DATA_W'($urandom_range(0, 15));
        else if (pick < 8)
            return DATA_W'(ACCOUNT_COUNT - 16 + $urandom_range(0, 15));
        else
            return DATA_W'($urandom_range(0, ACCOUNT_COUNT - 1));
    endfunction

    task automatic add_txn(input logic [CODE_W-1:0] op, input logic [DATA_W-1:0] sd,
                           input logic [CODE_W-1:0] rc, input logic [DATA_W-1:0] rd,
                           input logic [BAL_W-1:0] amt, input bit drain);
        t_pending p;
        p.txn.operation     = op;
        p.txn.sender_data   = sd;
        p.txn.receiver_code = rc;
        p.txn.receiver_data = rd;
        p.txn.amount        = amt;
        p.drain             = drain;
        txn_q.push_back(p);
    endtask

    // Range fill start just past the table or with high bits set.
    function automatic logic [DATA_W-1:0] DATA_DATA_FIX(input int sub);
        return (sub == 8) ? DATA_ONES : DATA_W'(ACCOUNT_COUNT);
    endfunction

    function automatic t_in make_random_txn(input int idx);
        t_in t;
        int  roll;
        int  sub;
        roll = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        t.operation     = OP_TRANSFER;
        t.receiver_code = OP_TRANSFER;
        t.sender_data   = pick_account();
        t.receiver_data = pick_account();
        t.amount        = BAL_W'($urandom_range(0, 300000));
        if (idx == 700 || idx == 1300) begin
            // whole-table fill, length to or past the end
            t.operation     = OP_RANGE_SET;
            t.receiver_code = OP_RANGE_SET;
            t.sender_data   = '0;
            t.receiver_data = DATA_W'(ACCOUNT_COUNT + $urandom_range(0, 1000));
            t.amount        = rand64();
        end else if (roll < 45) begin
            if (sub == 0)
                t.amount = rand64();
            else if (sub == 1)
                t.amount = -BAL_W'($urandom_range(1, 5000));
            else if (sub == 2)
                t.amount = START_BALANCE + BAL_W'($urandom_range(0, 100000));
        end else if (roll < 65) begin
            t.operation     = OP_RANGE_SET;
            t.receiver_code = OP_RANGE_SET;
            if (sub < 2) begin
                // clipped at the table end
                t.sender_data   = DATA_W'(ACCOUNT_COUNT - 16 + $urandom_range(0, 15));
                t.receiver_data = rand60();
            end else if (sub == 2) begin
                t.receiver_data = '0;
            end else begin
                t.receiver_data = DATA_W'($urandom_range(1, 6));
            end
            t.amount = ($urandom_range(0, 1)) ? rand64() : BAL_W'($urandom_range(0, 2000000));
        end else if (roll < 75) begin
            // index off the table
            if ($urandom_range(0, 1)) begin
                t.operation     = OP_RANGE_SET;
                t.receiver_code = OP_RANGE_SET;
                t.receiver_data = DATA_W'($urandom_range(1, 6));
            end
            if (sub < 5)
                t.sender_data = DATA_W'(ACCOUNT_COUNT + $urandom_range(0, 3));
            else if (sub < 7)
                t.sender_data = rand60();
            else if (t.operation == OP_TRANSFER)
                t.receiver_data = (sub == 7) ? DATA_W'(ACCOUNT_COUNT) : rand60();
            else
                t.sender_data = DATA_DATA_FIX(sub);
        end else if (roll < 85) begin
            // broken code pairs
            case (sub % 4)
                0: begin t.operation = OP_TRANSFER;  t.receiver_code = OP_RANGE_SET; end
                1: begin t.operation = OP_RANGE_SET; t.receiver_code = OP_TRANSFER;  end
                2: t.operation     = CODE_W'($urandom_range(2, 15));
                default: t.receiver_code = CODE_W'($urandom_range(2, 15));
            endcase
        end else begin
            t.operation     = CODE_W'($urandom_range(0, 15));
            t.receiver_code = CODE_W'($urandom_range(0, 15));
            t.sender_data   = rand60();
            t.receiver_data = rand60();
            t.amount        = rand64();
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [BAL_W-1:0] got,
                                   input logic [BAL_W-1:0] want);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP)
            $display("tb: result %0d: %s got %0h expected %0h", n_recv, what, got, want);
    endtask

    // Driver: one item held on the input until it is taken.
    always @(posedge i_clk) begin : drive_proc
        logic     next_valid;
        t_in      next_item;
        t_pending head;
        next_valid = i_in_valid;
        next_item  = i_in_item;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                totals_q.push_back(post_ledger_txn(i_in_item));
                n_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && txn_q.size() != 0) begin
                head = txn_q[0];
                if (!(head.drain && totals_q.size() != 0) &&
                    ((n_sent >= STEADY_LO && n_sent < STEADY_HI) ||
                     $urandom_range(0, 99) >= 30)) begin
                    void'(txn_q.pop_front());
                    next_item  = head.txn;
                    next_valid = 1'b1;
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_item  <= next_item;
    end

    // Monitor: compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin : check_proc
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_recv++;
            if (totals_q.size() == 0) begin
                report_mismatch("unexpected result", BAL_W'(o_out_item), '0);
            end else begin
                want = totals_q.pop_front();
                if (o_out_item.accepted !== want.accepted)
                    report_mismatch("accepted", BAL_W'(o_out_item.accepted),
                                    BAL_W'(want.accepted));
                if (o_out_item.success_total !== want.success_total)
                    report_mismatch("success_total", BAL_W'(o_out_item.success_total),
                                    BAL_W'(want.success_total));
                if (o_out_item.failure_total !== want.failure_total)
                    report_mismatch("failure_total", BAL_W'(o_out_item.failure_total),
                                    BAL_W'(want.failure_total));
            end
        end
        i_out_ready <= (n_recv >= STEADY_LO && n_recv < STEADY_HI) ||
                       ($urandom_range(0, 99) >= 30);
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: timeout after %0d quiet cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : run_proc
        int i;
        for (i = 0; i < ACCOUNT_COUNT; i++)
            ledger[i] = START_BALANCE;
        applied_total  = '0;
        rejected_total = '0;
        n_sent = 0;
        n_recv = 0;
        n_mismatch = 0;
        n_xfer_ok = 0;
        n_fill_ok = 0;
        n_reject = 0;

        // zero amount, exact balance, then overdraw
        add_txn(OP_TRANSFER, 60'd0, OP_TRANSFER, 60'd1, 64'd0, 1'b0);
        add_txn(OP_TRANSFER, 60'd0, OP_TRANSFER, 60'd1, START_BALANCE, 1'b0);
        add_txn(OP_TRANSFER, 60'd0, OP_TRANSFER, 60'd1, 64'd1, 1'b0);
        // self transfer and a negative amount
        add_txn(OP_TRANSFER, 60'd2, OP_TRANSFER, 60'd2, 64'd500, 1'b0);
        add_txn(OP_TRANSFER, 60'd3, OP_TRANSFER, 60'd4, -64'sd5, 1'b0);
        // indexes off the table, then the last account
        add_txn(OP_TRANSFER, DATA_W'(ACCOUNT_COUNT), OP_TRANSFER, 60'd0, 64'd1, 1'b0);
        add_txn(OP_TRANSFER, 60'd0, OP_TRANSFER, DATA_ONES, 64'd0, 1'b0);
        add_txn(OP_TRANSFER, DATA_W'(ACCOUNT_COUNT - 1), OP_TRANSFER, 60'd0, 64'd10, 1'b0);
        // fill with zero length, start off the table, start all ones
        add_txn(OP_RANGE_SET, 60'd10, OP_RANGE_SET, 60'd0, 64'd7, 1'b0);
        add_txn(OP_RANGE_SET, DATA_W'(ACCOUNT_COUNT), OP_RANGE_SET, 60'd1, 64'd7, 1'b0);
        add_txn(OP_RANGE_SET, DATA_ONES, OP_RANGE_SET, 60'd1, 64'd7, 1'b0);
        // largest positive value, then a transfer that wraps it
        add_txn(OP_RANGE_SET, 60'd5, OP_RANGE_SET, 60'd3, AMT_MAX, 1'b0);
        add_txn(OP_TRANSFER, 60'd1, OP_TRANSFER, 60'd5, 64'd2000000, 1'b0);
        // clipped fill of the most negative value, moved out by an equal amount
        add_txn(OP_RANGE_SET, DATA_W'(ACCOUNT_COUNT - 6), OP_RANGE_SET, DATA_ONES,
                AMT_MIN, 1'b0);
        add_txn(OP_TRANSFER, DATA_W'(ACCOUNT_COUNT - 5), OP_TRANSFER, 60'd6, AMT_MIN, 1'b0);
        // code pairs that must be refused
        add_txn(OP_TRANSFER, 60'd0, OP_RANGE_SET, 60'd1, 64'd0, 1'b0);
        add_txn(OP_RANGE_SET, 60'd0, OP_TRANSFER, 60'd1, 64'd0, 1'b0);
        add_txn(OP_SPARE, 60'd0, OP_SPARE, 60'd1, 64'd0, 1'b0);
        add_txn(OP_TOP_CODE, DATA_ONES, OP_TOP_CODE, DATA_ONES, AMT_MIN, 1'b0);
        // whole table back to the opening balance, drained before the next
        add_txn(OP_RANGE_SET, 60'd0, OP_RANGE_SET, DATA_W'(ACCOUNT_COUNT), START_BALANCE,
                1'b0);
        add_txn(OP_TRANSFER, 60'd7, OP_TRANSFER, 60'd8, START_BALANCE + 64'd1, 1'b1);
        add_txn(OP_RANGE_SET, 60'd0, OP_RANGE_SET, 60'd1, 64'd0, 1'b0);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            t_pending p;
            p.txn   = make_random_txn(i);
            p.drain = (i % 400 == 0);
            txn_q.push_back(p);
        end

        while (txn_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (totals_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d items sent, %0d results checked, %0d mismatches", n_sent, n_recv,
                 n_mismatch);
        $display("tb: %0d transfers and %0d range fills applied, %0d refused", n_xfer_ok,
                 n_fill_ok, n_reject);
        if (n_mismatch == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
